/* rtl/core/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants and types of the streaming pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

   localparam int PATTERN_MAX   = 16;
   localparam int BYTE_BITS     = 8;
   localparam int LEN_BITS      = 5;
   localparam int IDX_BITS      = $clog2(PATTERN_MAX);
   localparam int POSITION_BITS = 32;
   localparam int START_BITS    = 32;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int REG_SEL_LSB   = 3;

   // register select codes, taken from paddr[4:3]
   localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic [PATTERN_MAX-1:0][BYTE_BITS-1:0] pattern;
      logic [LEN_BITS-1:0]                   length;
      logic                                  clear;
   } cfg_type;

endpackage : kmp_pkg

`default_nettype wire

/* rtl/core/kmp_cell.sv */
// ----------------------------------------------------------------------------
// kmp_cell
// One stage of the comparator chain: remembers whether the text seen so far
// ends in the pattern prefix that closes at this cell's byte.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          clear,
   input  wire logic [kmp_pkg::BYTE_BITS-1:0] text_byte,
   input  wire logic [kmp_pkg::BYTE_BITS-1:0] pattern_byte,
   input  wire logic                          link_in,
   output logic                               hit,
   output logic                               match_out
);

   logic match_ff;
   logic match_in;

   // prefix up to the left neighbor matched and this byte extends it
   assign hit = link_in & (text_byte == pattern_byte);

   always_comb begin
      match_in = match_ff;
      if (clear) begin
         match_in = 1'b0;
      end else if (advance) begin
         match_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_out = match_ff;

endmodule : kmp_cell

`default_nettype wire

/* rtl/core/kmp_csr.sv */
// ----------------------------------------------------------------------------
// kmp_csr
// Register file holding the pattern bytes and pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [kmp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [kmp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [kmp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready,
   output kmp_pkg::cfg_type                       cfg
);

   logic [kmp_pkg::CSR_DATA_BITS-1:0] pat_low_ff,  pat_low_in;
   logic [kmp_pkg::CSR_DATA_BITS-1:0] pat_high_ff, pat_high_in;
   logic [kmp_pkg::LEN_BITS-1:0]      len_ff,      len_in;
   logic [1:0]                        reg_sel;
   logic                              wr_en;
   logic                              wr_hit;

   assign reg_sel = paddr[kmp_pkg::CSR_ADDR_BITS-1:kmp_pkg::REG_SEL_LSB];
   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      len_in      = len_ff;
      wr_hit      = 1'b0;
      prdata      = '0;
      unique case (reg_sel)
         kmp_pkg::REG_PATTERN_LOW: begin
            prdata = pat_low_ff;
            wr_hit = wr_en;
            if (wr_en) pat_low_in = pwdata;
         end
         kmp_pkg::REG_PATTERN_HIGH: begin
            prdata = pat_high_ff;
            wr_hit = wr_en;
            if (wr_en) pat_high_in = pwdata;
         end
         kmp_pkg::REG_PATTERN_LENGTH: begin
            prdata = kmp_pkg::CSR_DATA_BITS'(len_ff);
            wr_hit = wr_en;
            if (wr_en) len_in = pwdata[kmp_pkg::LEN_BITS-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_ff      <= kmp_pkg::LEN_BITS'(1);
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         len_ff      <= len_in;
      end
   end

   // clamp length into 1..PATTERN_MAX
   always_comb begin
      cfg.pattern = {pat_high_ff, pat_low_ff};
      cfg.clear   = wr_hit;
      if (len_ff == '0) begin
         cfg.length = kmp_pkg::LEN_BITS'(1);
      end else if (len_ff > kmp_pkg::LEN_BITS'(kmp_pkg::PATTERN_MAX)) begin
         cfg.length = kmp_pkg::LEN_BITS'(kmp_pkg::PATTERN_MAX);
      end else begin
         cfg.length = len_ff;
      end
   end

endmodule : kmp_csr

`default_nettype wire

/* rtl/core/kmp_stream_matcher_top.sv */
// ----------------------------------------------------------------------------
// kmp_stream_matcher_top
// Streaming matcher of a configurable pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle unless req_stall is set and
// returns one result per byte through a result register; a new byte is
// accepted in the same cycle that the waiting result is taken. The rate is
// set by a row of 16 comparator cells, one per pattern byte, each of which
// compares the incoming byte and hands its prefix-match flag to the next
// cell on every accepted byte, so every occurrence (overlapping ones too)
// is found without a failure-table walk. A result carries match_found and,
// on a match, the 32-bit text position of the occurrence's first byte
// (zero otherwise). Writing any pattern register clears the partial match;
// the text position is kept until a byte with start_of_text arrives.
`default_nettype none

module kmp_stream_matcher_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [kmp_pkg::BYTE_BITS-1:0]         req_text_byte,
   input  wire logic                                  req_start_of_text,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_match_found,
   output logic      [kmp_pkg::START_BITS-1:0]        rsp_match_start,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [kmp_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [kmp_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [kmp_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready
);

   kmp_pkg::cfg_type cfg;

   logic                                 accept;
   logic [kmp_pkg::PATTERN_MAX-1:0]      hit;
   logic [kmp_pkg::PATTERN_MAX-1:0]      link;
   logic [kmp_pkg::PATTERN_MAX-1:0]      match_q;
   logic [kmp_pkg::LEN_BITS-1:0]         len_m1;
   logic                                 found;
   logic [kmp_pkg::POSITION_BITS-1:0]    pos_ff, pos_in, cur_pos;
   logic [kmp_pkg::POSITION_BITS-1:0]    start_pos;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 found_ff, found_in;
   logic [kmp_pkg::START_BITS-1:0]       start_ff, start_in;

   kmp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // cell 0 always starts a new prefix; a start flag drops the older ones
   assign link[0] = 1'b1;

   for (genvar j = 0; j < kmp_pkg::PATTERN_MAX; j++) begin : g_cell
      if (j > 0) begin : g_link
         assign link[j] = match_q[j-1] & ~req_start_of_text;
      end
      kmp_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (accept),
         .clear        (cfg.clear),
         .text_byte    (req_text_byte),
         .pattern_byte (cfg.pattern[j]),
         .link_in      (link[j]),
         .hit          (hit[j]),
         .match_out    (match_q[j])
      );
   end

   assign len_m1    = cfg.length - kmp_pkg::LEN_BITS'(1);
   assign found     = hit[len_m1[kmp_pkg::IDX_BITS-1:0]];
   assign cur_pos   = req_start_of_text ? '0 : pos_ff;
   assign start_pos = cur_pos + kmp_pkg::POSITION_BITS'(1)
                      - kmp_pkg::POSITION_BITS'(cfg.length);

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      if (accept) begin
         pos_in       = cur_pos + kmp_pkg::POSITION_BITS'(1);
         rsp_valid_in = 1'b1;
         found_in     = found;
         start_in     = found ? kmp_pkg::START_BITS'(start_pos) : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      start_ff <= start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = found_ff;
   assign rsp_match_start = start_ff;

endmodule : kmp_stream_matcher_top

`default_nettype wire

/* rtl/core/kmp_checker.sv */
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_match_found,
   input  wire logic [kmp_pkg::START_BITS-1:0]    rsp_match_start
);

   // a transaction always produces a result in the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // input only backs up while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no waiting result");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match_found) |-> (rsp_match_start == '0))
      else $error("match start set without a match");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall) |->
         (rsp_valid && $stable(rsp_match_found) && $stable(rsp_match_start)))
      else $error("stalled result changed");

endmodule : kmp_checker

bind kmp_stream_matcher_top kmp_checker u_kmp_checker (.*);

`default_nettype wire

/* bench/tb_kmp_stream_matcher_top.sv */
// ----------------------------------------------------------------------------
// tb_kmp_stream_matcher_top
// Self-checking bench of the streaming pattern matcher.
// ----------------------------------------------------------------------------
// A prefix-function predictor tracks pattern registers, partial match and
// text position, and queues one expected result per accepted text byte.
// Directed checks cover the reset pattern, overlapping matches, a restart
// in mid-match, writes to an unused address and out-of-range lengths.
// Random phases then reprogram the pattern and stream occurrences, broken
// prefixes and noise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_kmp_stream_matcher_top;

   localparam int          CLOCK_PERIOD    = 12;
   localparam int          RESET_CYCLES    = 5;
   localparam longint      CYCLE_LIMIT     = 600000;
   localparam int unsigned RANDOM_ITEMS    = 830;
   localparam int          HOLD_OFF_CYCLES = 160;
   localparam int          SETTLE_CYCLES   = 3;
   localparam logic [1:0]  REG_UNUSED      = 2'd3;

   typedef struct packed {
      logic                           found;
      logic [kmp_pkg::START_BITS-1:0] start;
   } match_rec_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [kmp_pkg::BYTE_BITS-1:0]     req_text_byte = '0;
   logic                              req_start_of_text = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_match_found;
   logic [kmp_pkg::START_BITS-1:0]    rsp_match_start;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [kmp_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [kmp_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [kmp_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   // predictor state
   logic [63:0]                       pat_lo_reg;
   logic [63:0]                       pat_hi_reg;
   logic [kmp_pkg::LEN_BITS-1:0]      pat_len_reg;
   logic [kmp_pkg::LEN_BITS-1:0]      border_len [kmp_pkg::PATTERN_MAX];
   logic [kmp_pkg::LEN_BITS-1:0]      partial_len;
   logic [kmp_pkg::POSITION_BITS-1:0] text_pos;

   match_rec_type awaited_matches [$];
   int            error_count = 0;
   int unsigned   items_sent = 0;
   longint        cycle_count = 0;
   bit            req_idle_on = 1'b1;
   bit            rsp_idle_on = 1'b1;
   int            hold_off_cycles = 0;

   kmp_stream_matcher_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_start_of_text (req_start_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_found   (rsp_match_found),
      .rsp_match_start   (rsp_match_start),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** kmp_stream_matcher_top: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned active_length();
      int unsigned n;
      n = 32'(pat_len_reg);
      if (n == 0) n = 1;
      if (n > kmp_pkg::PATTERN_MAX) n = kmp_pkg::PATTERN_MAX;
      return n;
   endfunction

   function automatic logic [kmp_pkg::BYTE_BITS-1:0] pattern_byte(input int unsigned idx);
      int unsigned i;
      i = idx % kmp_pkg::PATTERN_MAX;
      if (i < 8) return pat_lo_reg[8*i +: 8];
      return pat_hi_reg[8*(i-8) +: 8];
   endfunction

   // longest proper border of every pattern prefix; clears the partial match
   function automatic void rebuild_borders();
      int unsigned len;
      int unsigned k;
      int unsigned i;
      len = active_length();
      k = 0;
      for (i = 0; i < kmp_pkg::PATTERN_MAX; i++) border_len[i] = '0;
      for (i = 1; i < len; i++) begin
         while (k > 0 && pattern_byte(i) != pattern_byte(k))
            k = 32'(border_len[k-1]);
         if (pattern_byte(i) == pattern_byte(k)) k++;
         border_len[i] = k[kmp_pkg::LEN_BITS-1:0];
      end
      partial_len = '0;
   endfunction

   function automatic void apply_register(input logic [1:0] sel, input logic [63:0] value);
      case (sel)
         kmp_pkg::REG_PATTERN_LOW: begin
            pat_lo_reg = value;
            rebuild_borders();
         end
         kmp_pkg::REG_PATTERN_HIGH: begin
            pat_hi_reg = value;
            rebuild_borders();
         end
         kmp_pkg::REG_PATTERN_LENGTH: begin
            pat_len_reg = value[kmp_pkg::LEN_BITS-1:0];
            rebuild_borders();
         end
         default: begin
            // unused address: no effect at all
         end
      endcase
   endfunction

   function automatic match_rec_type scan_byte(input logic [kmp_pkg::BYTE_BITS-1:0] text,
                                               input logic first);
      int unsigned   len;
      int unsigned   k;
      match_rec_type rec;
      len = active_length();
      rec = '0;
      if (first) begin
         text_pos = '0;
         partial_len = '0;
      end
      k = 32'(partial_len);
      if (k >= len) k = 0;
      while (k > 0 && text != pattern_byte(k)) k = 32'(border_len[k-1]);
      if (text == pattern_byte(k)) k++;
      if (k >= len) begin
         rec.found = 1'b1;
         rec.start = kmp_pkg::START_BITS'(text_pos - kmp_pkg::POSITION_BITS'(len)
                                          + kmp_pkg::POSITION_BITS'(1));
         // fall back so that overlapping occurrences are still found
         k = 32'(border_len[len-1]);
      end
      partial_len = k[kmp_pkg::LEN_BITS-1:0];
      text_pos = text_pos + kmp_pkg::POSITION_BITS'(1);
      return rec;
   endfunction

   // ------------------------------------------------------------------------
   // result channel: stall generation and checking
   // ------------------------------------------------------------------------
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   initial begin : rsp_stall_driver
      int unsigned run_left;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b1;
            run_left--;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 25) begin
            rsp_stall <= 1'b1;
            run_left = idle_length() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      match_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_matches.size() == 0) begin
            $error("unexpected result: match_found=%0b match_start=%0d",
                   rsp_match_found, rsp_match_start);
            error_count++;
         end else begin
            want = awaited_matches.pop_front();
            if (rsp_match_found !== want.found) begin
               $error("match_found: expected %0b, actual %0b",
                      want.found, rsp_match_found);
               error_count++;
            end
            if (rsp_match_start !== want.start) begin
               $error("match_start: expected %0d, actual %0d",
                      want.start, rsp_match_start);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_text(input logic [kmp_pkg::BYTE_BITS-1:0] text, input logic first);
      int unsigned idle;
      req_valid <= 1'b1;
      req_text_byte <= text;
      req_start_of_text <= first;
      do @(posedge clock); while (req_stall);
      awaited_matches.insert(awaited_matches.size(), scan_byte(text, first));
      items_sent++;
      if (req_idle_on && $urandom_range(0, 99) < 30) begin
         idle = idle_length();
         req_valid <= 1'b0;
         req_text_byte <= 8'($urandom_range(0, 255));
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic feed_byte(input logic [kmp_pkg::BYTE_BITS-1:0] text);
      send_text(text, $urandom_range(0, 49) == 0);
   endtask

   // hold the sender until every queued result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] sel, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= kmp_pkg::CSR_ADDR_BITS'(sel) << kmp_pkg::REG_SEL_LSB;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_register(sel, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_pattern();
      // reset pattern is a single zero byte
      send_text(8'h00, 1'b0);
      send_text(8'hFF, 1'b0);
      send_text(8'h00, 1'b1);
      drain_results();
   endtask

   task automatic test_overlapping_matches();
      write_register(kmp_pkg::REG_PATTERN_LOW, 64'h0000_0000_6261_6261);   // "abab"
      write_register(kmp_pkg::REG_PATTERN_HIGH, 64'h0);
      write_register(kmp_pkg::REG_PATTERN_LENGTH, 64'd4);
      send_text(8'h61, 1'b1);
      send_text(8'h62, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b0);
      // restart in mid-match: the partial match must be dropped
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b1);
      drain_results();
   endtask

   task automatic test_unused_register();
      send_text(8'h61, 1'b1);
      send_text(8'h62, 1'b0);
      drain_results();
      // an unused address must leave the partial match alone
      write_register(REG_UNUSED, '1);
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b0);
      drain_results();
   endtask

   task automatic test_length_limits();
      write_register(kmp_pkg::REG_PATTERN_LOW, '1);
      write_register(kmp_pkg::REG_PATTERN_HIGH, '1);
      write_register(kmp_pkg::REG_PATTERN_LENGTH, 64'd0);
      send_text(8'hFF, 1'b0);
      send_text(8'h00, 1'b0);
      drain_results();
      write_register(kmp_pkg::REG_PATTERN_LENGTH, 64'd31);
      send_text(8'hFF, 1'b0);
      send_text(8'hFF, 1'b0);
      drain_results();
   endtask

   task automatic test_backpressure();
      int unsigned j;
      write_register(kmp_pkg::REG_PATTERN_LOW, 64'h0000_0000_0041_4141);   // "AAA"
      write_register(kmp_pkg::REG_PATTERN_LENGTH, 64'd3);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_off_cycles = HOLD_OFF_CYCLES;
      for (j = 0; j < 48; j++) feed_byte(($urandom_range(0, 5) == 0) ? 8'h42 : 8'h41);
      drain_results();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_streams();
      logic [kmp_pkg::BYTE_BITS-1:0] alphabet [3];
      logic [63:0]                   words [2];
      logic [63:0]                   len_word;
      logic [1:0]                    reg_order [3];
      logic [1:0]                    sel;
      int unsigned                   first_item;
      int unsigned                   chunk_end;
      int unsigned                   alpha_n;
      int unsigned                   len_eff;
      int unsigned                   pick;
      int unsigned                   piece;
      int unsigned                   rotate;
      int unsigned                   j;
      bit                            raw;
      reg_order[0] = kmp_pkg::REG_PATTERN_LOW;
      reg_order[1] = kmp_pkg::REG_PATTERN_HIGH;
      reg_order[2] = kmp_pkg::REG_PATTERN_LENGTH;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         drain_results();
         // small alphabets make occurrences and borders frequent
         raw = ($urandom_range(0, 7) == 0);
         alpha_n = $urandom_range(1, 3);
         foreach (alphabet[a]) alphabet[a] = 8'($urandom_range(0, 255));
         for (j = 0; j < kmp_pkg::PATTERN_MAX; j++) begin
            words[j / 8][8*(j%8) +: 8] = raw ? 8'($urandom_range(0, 255))
                                             : alphabet[$urandom_range(0, alpha_n - 1)];
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) len_word = 64'($urandom_range(1, 5));
         else if (pick < 80) len_word = 64'($urandom_range(6, 15));
         else if (pick < 92) len_word = 64'd16;
         else if (pick < 96) len_word = 64'd0;
         else len_word = 64'($urandom_range(17, 31));
         if (raw) begin
            len_word[63:kmp_pkg::LEN_BITS] =
               (64 - kmp_pkg::LEN_BITS)'({$urandom(), $urandom()});
         end
         rotate = $urandom_range(0, 2);
         for (j = 0; j < 3; j++) begin
            sel = reg_order[(j + rotate) % 3];
            write_register(sel, (sel == kmp_pkg::REG_PATTERN_LOW)  ? words[0] :
                                (sel == kmp_pkg::REG_PATTERN_HIGH) ? words[1] : len_word);
         end
         if ($urandom_range(0, 5) == 0) write_register(REG_UNUSED, {$urandom(), $urandom()});

         len_eff = active_length();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         chunk_end = items_sent + $urandom_range(20, 60);
         while (items_sent < chunk_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) piece = len_eff;
            else if (pick < 65) piece = $urandom_range(1, len_eff);
            else piece = 0;
            if (piece > 0) begin
               for (j = 0; j < piece; j++) feed_byte(pattern_byte(j));
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4))
                  feed_byte(alphabet[$urandom_range(0, alpha_n - 1)]);
            end else begin
               feed_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      pat_lo_reg = '0;
      pat_hi_reg = '0;
      pat_len_reg = kmp_pkg::LEN_BITS'(1);
      text_pos = '0;
      rebuild_borders();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_pattern();
      test_overlapping_matches();
      test_unused_register();
      test_length_limits();
      test_backpressure();
      test_random_streams();

      drain_results();
      if (error_count == 0 && awaited_matches.size() == 0) begin
         $display("** kmp_stream_matcher_top: PASSED **");
      end else begin
         $display("** kmp_stream_matcher_top: FAILED **");
      end
      $finish;
   end

endmodule
